/* hw/rtl/bscm_pkg.sv */
// ----------------------------------------------------------------------------
// bscm_pkg
// shared constants, register indexes and controller/datapath link types
// ----------------------------------------------------------------------------
package bscm_pkg;

  localparam int DEF_MAX_TIME_LEN = 1024;
  localparam int DEF_MAX_BANDS    = 64;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 31;
  localparam int ENERGY_W   = 32;
  localparam int SUM_W      = 38;
  localparam int MAG_W      = 19;
  localparam int TIDX_W     = 10;
  localparam int TL_W       = 11;
  localparam int BC_W       = 7;
  localparam int EPS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // radix-4 digit steps of the square root
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS);
  localparam int REM_W    = MAG_W + 2;

  localparam logic [TL_W-1:0]  TL_RESET  = 11'd1024;
  localparam logic [BC_W-1:0]  BC_RESET  = 7'd1;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_LEN   = 2'd0,
    REG_BAND_COUNT = 2'd1,
    REG_EPS_ADD    = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic sq_load;
    logic sq_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_band;
    logic sq_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/bscm_if.sv */
// ----------------------------------------------------------------------------
// bscm channel interfaces
// valid/ready channels for complex samples and magnitude results
// ----------------------------------------------------------------------------
interface bscm_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bscm_pkg::SAMPLE_W-1:0] real_part;
  logic signed [bscm_pkg::SAMPLE_W-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

interface bscm_result_if;
  logic                        valid;
  logic                        ready;
  logic [bscm_pkg::MAG_W-1:0]  magnitude;
  logic [bscm_pkg::TIDX_W-1:0] time_index;
  logic                        row_last;

  modport source (output valid, output magnitude, output time_index, output row_last,
                  input ready);
  modport sink (input valid, input magnitude, input time_index, input row_last,
                output ready);
endinterface

/* hw/rtl/bscm_ram.sv */
// ----------------------------------------------------------------------------
// bscm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bscm_ctrl.sv */
// ----------------------------------------------------------------------------
// bscm_ctrl
// sequencer: request capture, multiply, accumulate, square root, result load
// ----------------------------------------------------------------------------
module bscm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bscm_pkg::sts_t  sts,
  output bscm_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_SQL  = 6'b001000,
    ST_SQS  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last_band ? ST_SQL : ST_IDLE;
      end
      ST_SQL: begin
        cmd.sq_load = 1'b1;
        state_next  = ST_SQS;
      end
      ST_SQS: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/bscm_dp.sv */
// ----------------------------------------------------------------------------
// bscm_dp
// datapath: config registers, counters, energy ram, bit-serial square root,
// result register
// ----------------------------------------------------------------------------
module bscm_dp #(
  parameter int MAX_TIME_LEN = bscm_pkg::DEF_MAX_TIME_LEN,
  parameter int MAX_BANDS    = bscm_pkg::DEF_MAX_BANDS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bscm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bscm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic signed [bscm_pkg::SAMPLE_W-1:0] real_part,
  input  logic signed [bscm_pkg::SAMPLE_W-1:0] imag_part,
  input  bscm_pkg::cmd_t                       cmd,
  output bscm_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bscm_pkg::MAG_W-1:0]           magnitude,
  output logic [bscm_pkg::TIDX_W-1:0]          time_index,
  output logic                                 row_last
);

  localparam int TW     = (MAX_TIME_LEN > 1) ? $clog2(MAX_TIME_LEN) : 1;
  localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CTW    = ((TW > bscm_pkg::TL_W) ? TW : bscm_pkg::TL_W) + 1;
  localparam int CBW    = ((BW > bscm_pkg::BC_W) ? BW : bscm_pkg::BC_W) + 1;
  localparam int TL_MAX = (1 << bscm_pkg::TL_W) - 1;
  localparam int BC_MAX = (1 << bscm_pkg::BC_W) - 1;
  localparam int TL_CAP = (MAX_TIME_LEN > TL_MAX) ? TL_MAX : MAX_TIME_LEN;
  localparam int BC_CAP = (MAX_BANDS > BC_MAX) ? BC_MAX : MAX_BANDS;

  // configuration
  logic [bscm_pkg::TL_W-1:0]  tl_reg;
  logic [bscm_pkg::BC_W-1:0]  bc_reg;
  logic [bscm_pkg::EPS_W-1:0] eps_reg;
  logic [bscm_pkg::TL_W-1:0]  eff_tl;
  logic [bscm_pkg::BC_W-1:0]  eff_bc;
  logic                       cnt_clear;

  // position counters
  logic [TW-1:0] t_cnt;
  logic [BW-1:0] b_cnt;
  logic          last_time;
  logic          last_band;

  // captured request
  logic signed [bscm_pkg::SAMPLE_W-1:0] re_cap;
  logic signed [bscm_pkg::SAMPLE_W-1:0] im_cap;
  logic [TW-1:0]                        t_cap;
  logic                                 first_cap;
  logic                                 last_band_cap;
  logic                                 last_time_cap;

  // energy
  logic [bscm_pkg::PROD_W-1:0]   prod_re;
  logic [bscm_pkg::PROD_W-1:0]   prod_im;
  logic signed [2*bscm_pkg::SAMPLE_W-1:0] sq_re;
  logic signed [2*bscm_pkg::SAMPLE_W-1:0] sq_im;
  logic [bscm_pkg::ENERGY_W-1:0] energy;
  logic [bscm_pkg::SUM_W-1:0]    ram_rdata;
  logic [bscm_pkg::SUM_W-1:0]    sum_new;
  logic [bscm_pkg::SUM_W-1:0]    sum_reg;

  // square root
  logic [bscm_pkg::SUM_W-1:0]    rad;
  logic [bscm_pkg::REM_W-1:0]    rem;
  logic [bscm_pkg::MAG_W-1:0]    root;
  logic [bscm_pkg::SQ_CNT_W-1:0] sq_cnt;
  logic [bscm_pkg::REM_W+1:0]    rem_sh;
  logic [bscm_pkg::REM_W+1:0]    trial;
  logic                          take;
  logic [bscm_pkg::MAG_W-1:0]    mag_round;

  assign cnt_clear = cfg_we && ((cfg_index == bscm_pkg::REG_TIME_LEN)
                                || (cfg_index == bscm_pkg::REG_BAND_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      tl_reg  <= bscm_pkg::TL_RESET;
      bc_reg  <= bscm_pkg::BC_RESET;
      eps_reg <= bscm_pkg::EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bscm_pkg::REG_TIME_LEN:   tl_reg  <= cfg_wdata[bscm_pkg::TL_W-1:0];
        bscm_pkg::REG_BAND_COUNT: bc_reg  <= cfg_wdata[bscm_pkg::BC_W-1:0];
        bscm_pkg::REG_EPS_ADD:    eps_reg <= cfg_wdata[bscm_pkg::EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (tl_reg == '0) begin
      eff_tl = bscm_pkg::TL_W'(1);
    end else if (int'(tl_reg) > TL_CAP) begin
      eff_tl = bscm_pkg::TL_W'(TL_CAP);
    end else begin
      eff_tl = tl_reg;
    end
    if (bc_reg == '0) begin
      eff_bc = bscm_pkg::BC_W'(1);
    end else if (int'(bc_reg) > BC_CAP) begin
      eff_bc = bscm_pkg::BC_W'(BC_CAP);
    end else begin
      eff_bc = bc_reg;
    end
  end

  assign last_time = (CTW'(t_cnt) + CTW'(1)) >= CTW'(eff_tl);
  assign last_band = (CBW'(b_cnt) + CBW'(1)) >= CBW'(eff_bc);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_cnt <= '0;
      b_cnt <= '0;
    end else if (cnt_clear) begin
      t_cnt <= '0;
      b_cnt <= '0;
    end else if (cmd.capture) begin
      if (last_time) begin
        t_cnt <= '0;
        b_cnt <= last_band ? '0 : b_cnt + BW'(1);
      end else begin
        t_cnt <= t_cnt + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      re_cap        <= real_part;
      im_cap        <= imag_part;
      t_cap         <= t_cnt;
      first_cap     <= (b_cnt == '0);
      last_band_cap <= last_band;
      last_time_cap <= last_time;
    end
  end

  bscm_ram #(
    .WIDTH (bscm_pkg::SUM_W),
    .DEPTH (MAX_TIME_LEN)
  ) u_energy_ram (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (t_cap),
    .wdata (sum_new),
    .re    (cmd.capture),
    .raddr (t_cnt),
    .rdata (ram_rdata)
  );

  assign sq_re = re_cap * re_cap;
  assign sq_im = im_cap * im_cap;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_re <= sq_re[bscm_pkg::PROD_W-1:0];
      prod_im <= sq_im[bscm_pkg::PROD_W-1:0];
    end
  end

  assign energy  = bscm_pkg::ENERGY_W'(prod_re) + bscm_pkg::ENERGY_W'(prod_im);
  assign sum_new = bscm_pkg::SUM_W'(energy) + (first_cap ? '0 : ram_rdata);

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sum_reg <= sum_new;
    end
  end

  // one result bit per step, two radicand bits in
  assign rem_sh = {rem, rad[bscm_pkg::SUM_W-1 -: 2]};
  assign trial  = (bscm_pkg::REM_W+2)'({root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      rad    <= sum_reg + bscm_pkg::SUM_W'(eps_reg);
      rem    <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end else if (cmd.sq_step) begin
      rad    <= {rad[bscm_pkg::SUM_W-3:0], 2'b00};
      rem    <= take ? bscm_pkg::REM_W'(rem_sh - trial) : bscm_pkg::REM_W'(rem_sh);
      root   <= {root[bscm_pkg::MAG_W-2:0], take};
      sq_cnt <= sq_cnt + bscm_pkg::SQ_CNT_W'(1);
    end
  end

  // round to nearest: up when the remainder exceeds the root
  assign mag_round = (rem > bscm_pkg::REM_W'(root)) ? root + bscm_pkg::MAG_W'(1) : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude  <= mag_round;
      time_index <= bscm_pkg::TIDX_W'(t_cap);
      row_last   <= last_time_cap;
    end
  end

  assign sts.last_band = last_band_cap;
  assign sts.sq_last   = (sq_cnt == bscm_pkg::SQ_CNT_W'(bscm_pkg::SQ_STEPS - 1));
  assign sts.out_free  = !out_valid || out_ready;

endmodule

/* hw/rtl/band_summed_complex_magnitude_top.sv */
// ----------------------------------------------------------------------------
// band_summed_complex_magnitude_top
// a non-final band request runs capture, multiply and accumulate, then the
// next request is accepted; a final band request also runs the bit-serial
// square root (one result bit per cycle, 19 steps) and loads the result
// register, which lets the next request in; stalls while an old result waits
// reset: counters to zero, registers to defaults, energy ram left as is
// ----------------------------------------------------------------------------
module band_summed_complex_magnitude_top #(
  parameter int MAX_TIME_LEN = bscm_pkg::DEF_MAX_TIME_LEN,
  parameter int MAX_BANDS    = bscm_pkg::DEF_MAX_BANDS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bscm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bscm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bscm_sample_if.sink                     sample,
  bscm_result_if.source                   result
);

  bscm_pkg::cmd_t cmd;
  bscm_pkg::sts_t sts;

  bscm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bscm_dp #(
    .MAX_TIME_LEN (MAX_TIME_LEN),
    .MAX_BANDS    (MAX_BANDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .real_part  (sample.real_part),
    .imag_part  (sample.imag_part),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .magnitude  (result.magnitude),
    .time_index (result.time_index),
    .row_last   (result.row_last)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_capture_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.mul ##1 cmd.acc)
    else $error("request not followed by multiply and accumulate");

  a_sqrt_start: assert property (@(posedge clk) disable iff (rst)
    cmd.sq_load |=> cmd.sq_step && !sample.ready)
    else $error("square root start broken");

  a_acc_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc && !sts.last_band) |=> sample.ready)
    else $error("non-final band did not return to accept");

endmodule
